// ----- hdl/rbsi_pkg.sv -----
// Shared types, constants and face-code helpers for the ray/box slab intersection unit.
package rbsi_pkg;

  // Default fixed-point format: signed Q16.16.
  localparam int unsigned COORD_BITS_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_BITS = 3;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_BOX_MIN_X = 3'd0;
  localparam cfg_idx_t REG_BOX_MIN_Y = 3'd1;
  localparam cfg_idx_t REG_BOX_MIN_Z = 3'd2;
  localparam cfg_idx_t REG_BOX_MAX_X = 3'd3;
  localparam cfg_idx_t REG_BOX_MAX_Y = 3'd4;
  localparam cfg_idx_t REG_BOX_MAX_Z = 3'd5;

  // Face codes reported with entry and exit.
  localparam int unsigned FACE_BITS = 3;
  typedef logic [FACE_BITS-1:0] face_t;

  localparam face_t FACE_NONE  = 3'd0;
  localparam face_t FACE_NEG_X = 3'd1;
  localparam face_t FACE_POS_X = 3'd2;
  localparam face_t FACE_NEG_Y = 3'd3;
  localparam face_t FACE_POS_Y = 3'd4;
  localparam face_t FACE_NEG_Z = 3'd5;
  localparam face_t FACE_POS_Z = 3'd6;

  localparam int unsigned NUM_AXES = 3;

  // Load enables for the per-axis pipeline stages.
  typedef struct packed {
    logic diff;
    logic prod;
    logic sat;
    logic order;
  } adv_t;

  function automatic face_t neg_face(input int unsigned axis);
    case (axis)
      0:       return FACE_NEG_X;
      1:       return FACE_NEG_Y;
      default: return FACE_NEG_Z;
    endcase
  endfunction

  function automatic face_t pos_face(input int unsigned axis);
    case (axis)
      0:       return FACE_POS_X;
      1:       return FACE_POS_Y;
      default: return FACE_POS_Z;
    endcase
  endfunction

endpackage

// ----- hdl/rbsi_slab_axis.sv -----
// One axis of the slab test: plane distances, fixed-point products and near/far ordering.
module rbsi_slab_axis #(
  parameter int unsigned COORD_BITS = rbsi_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = rbsi_pkg::FRAC_BITS_DEF,
  parameter int unsigned AXIS       = 0
) (
  input  logic                         clk_i,
  input  rbsi_pkg::adv_t               adv_i,
  input  logic signed [COORD_BITS-1:0] origin_i,
  input  logic signed [COORD_BITS-1:0] inv_dir_i,
  input  logic signed [COORD_BITS-1:0] box_min_i,
  input  logic signed [COORD_BITS-1:0] box_max_i,
  output logic signed [COORD_BITS-1:0] near_t_o,
  output logic signed [COORD_BITS-1:0] far_t_o,
  output rbsi_pkg::face_t              near_face_o,
  output rbsi_pkg::face_t              far_face_o
);
  import rbsi_pkg::*;

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * COORD_BITS + 1;
  localparam int unsigned HW = PW - COORD_BITS + 1;

  localparam logic signed [COORD_BITS-1:0] T_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] T_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic signed [DW-1:0]         dlo_q, dhi_q;
  logic signed [COORD_BITS-1:0] inv_q;
  logic signed [PW-1:0]         plo_q, phi_q;
  logic signed [COORD_BITS-1:0] t0_q, t1_q;
  logic signed [COORD_BITS-1:0] near_q, far_q;
  face_t                        near_face_q, far_face_q;

  // Floor division by 2^FRAC_BITS is an arithmetic shift; then clamp to the coordinate range.
  function automatic logic signed [COORD_BITS-1:0] sat_shift(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    logic [HW-1:0]        hi;
    s  = p >>> FRAC_BITS;
    hi = s[PW-1:COORD_BITS-1];
    if ((&hi) || (~|hi)) begin
      return s[COORD_BITS-1:0];
    end else if (s[PW-1]) begin
      return T_MIN;
    end else begin
      return T_MAX;
    end
  endfunction

  // Differences are exact, one bit wider than the coordinates.
  always_ff @(posedge clk_i) begin
    if (adv_i.diff) begin
      dlo_q <= DW'(box_min_i) - DW'(origin_i);
      dhi_q <= DW'(box_max_i) - DW'(origin_i);
      inv_q <= inv_dir_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.prod) begin
      plo_q <= PW'(dlo_q) * PW'(inv_q);
      phi_q <= PW'(dhi_q) * PW'(inv_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.sat) begin
      t0_q <= sat_shift(plo_q);
      t1_q <= sat_shift(phi_q);
    end
  end

  // Equal distances take the swapped order: the max plane becomes the near face.
  always_ff @(posedge clk_i) begin
    if (adv_i.order) begin
      if (t0_q < t1_q) begin
        near_q      <= t0_q;
        far_q       <= t1_q;
        near_face_q <= neg_face(AXIS);
        far_face_q  <= pos_face(AXIS);
      end else begin
        near_q      <= t1_q;
        far_q       <= t0_q;
        near_face_q <= pos_face(AXIS);
        far_face_q  <= neg_face(AXIS);
      end
    end
  end

  assign near_t_o    = near_q;
  assign far_t_o     = far_q;
  assign near_face_o = near_face_q;
  assign far_face_o  = far_face_q;

endmodule

// ----- hdl/ray_box_slab_intersect_unit.sv -----
// Top level of the ray versus axis-aligned box slab intersection unit.
// Pipeline: 7 register stages (input, diff, prod, sat, order, reduce, output) carry each request.
// Throughput: one request per cycle with the sink ready; a stage holds one ray, moving when the next is free.
// Stall: a stage empties or moves on as soon as its successor can take it, so bubbles collapse.
// Reset: rst_ni clears all valid flags; the box returns to min 0.0 and max 1.0 on each axis.
// Configuration is taken in any cycle, cfg_ready_o is always high.
module ray_box_slab_intersect_unit #(
  parameter int unsigned COORD_BITS = rbsi_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = rbsi_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,

  // Configuration write channel.
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  rbsi_pkg::cfg_idx_t                     cfg_index_i,
  input  logic [COORD_BITS-1:0]                  cfg_data_i,

  // Ray requests.
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // Fields from bit 0 up: origin_x, origin_y, origin_z, inv_dir_x, inv_dir_y, inv_dir_z,
  // ray_t_min, closest_t, each COORD_BITS wide, zero padding to whole bytes.
  input  logic [((8*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,

  // Intersection results.
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // Fields from bit 0 up: hit (1), entry_t, exit_t (COORD_BITS each), entry_face (3),
  // exit_face (3), zero padding to whole bytes.
  output logic [((2*COORD_BITS+7+7)/8)*8-1:0]    m_axis_tdata
);
  import rbsi_pkg::*;

  localparam int unsigned CB          = COORD_BITS;
  localparam int unsigned OUT_TDATA_W = ((2*COORD_BITS+7+7)/8)*8;
  localparam int unsigned NST         = 7;  // input, diff, prod, sat, order, reduce, output

  localparam int unsigned ST_IN     = 0;
  localparam int unsigned ST_DIFF   = 1;
  localparam int unsigned ST_PROD   = 2;
  localparam int unsigned ST_SAT    = 3;
  localparam int unsigned ST_ORDER  = 4;
  localparam int unsigned ST_REDUCE = 5;
  localparam int unsigned ST_OUT    = 6;

  localparam logic signed [CB-1:0] T_MAX   = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] ONE_FIX = {{(CB-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  // ---------------------------------------------------------------------------
  // Box corners. The user must write them only while no request is in flight; the block does not enforce this.
  // ---------------------------------------------------------------------------
  logic signed [CB-1:0] box_min_q [NUM_AXES];
  logic signed [CB-1:0] box_max_q [NUM_AXES];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        box_min_q[i] <= '0;
        box_max_q[i] <= ONE_FIX;
      end
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BOX_MIN_X: box_min_q[0] <= cfg_data_i;
        REG_BOX_MIN_Y: box_min_q[1] <= cfg_data_i;
        REG_BOX_MIN_Z: box_min_q[2] <= cfg_data_i;
        REG_BOX_MAX_X: box_max_q[0] <= cfg_data_i;
        REG_BOX_MAX_Y: box_max_q[1] <= cfg_data_i;
        REG_BOX_MAX_Z: box_max_q[2] <= cfg_data_i;
        default: ;  // Writes beyond the six box registers are dropped.
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control. A stage loads whenever it is empty or its content
  // moves on in the same cycle, so the chain runs at one request per cycle and
  // stalls only when every stage holds a ray.
  // ---------------------------------------------------------------------------
  logic [NST-1:0] vld_q, vld_d, rdy;
  adv_t           adv;

  always_comb begin
    rdy[NST-1] = !vld_q[NST-1] || m_axis_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (rdy[0]) begin
      vld_d[0] = s_axis_tvalid;
    end
    for (int k = 1; k < NST; k++) begin
      if (rdy[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign adv.diff       = rdy[ST_DIFF];
  assign adv.prod       = rdy[ST_PROD];
  assign adv.sat        = rdy[ST_SAT];
  assign adv.order      = rdy[ST_ORDER];

  assign s_axis_tready  = rdy[ST_IN];
  assign m_axis_tvalid  = vld_q[ST_OUT];

  // ---------------------------------------------------------------------------
  // Input register. The ray's bounds ride alongside the axis pipelines.
  // ---------------------------------------------------------------------------
  logic signed [CB-1:0] origin_q [NUM_AXES];
  logic signed [CB-1:0] inv_dir_q [NUM_AXES];
  logic signed [CB-1:0] tmin_q [ST_ORDER+1];
  logic signed [CB-1:0] closest_q [ST_ORDER+1];

  always_ff @(posedge clk_i) begin
    if (rdy[ST_IN]) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        origin_q[i]  <= s_axis_tdata[i*CB +: CB];
        inv_dir_q[i] <= s_axis_tdata[(NUM_AXES+i)*CB +: CB];
      end
      tmin_q[ST_IN]    <= s_axis_tdata[2*NUM_AXES*CB +: CB];
      closest_q[ST_IN] <= s_axis_tdata[(2*NUM_AXES+1)*CB +: CB];
    end
    for (int k = ST_DIFF; k <= ST_ORDER; k++) begin
      if (rdy[k]) begin
        tmin_q[k]    <= tmin_q[k-1];
        closest_q[k] <= closest_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Per-axis slab distances, one pipeline per axis.
  // ---------------------------------------------------------------------------
  logic signed [CB-1:0] near_t [NUM_AXES];
  logic signed [CB-1:0] far_t [NUM_AXES];
  face_t                near_face [NUM_AXES];
  face_t                far_face [NUM_AXES];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    rbsi_slab_axis #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .AXIS       (a)
    ) u_axis (
      .clk_i       (clk_i),
      .adv_i       (adv),
      .origin_i    (origin_q[a]),
      .inv_dir_i   (inv_dir_q[a]),
      .box_min_i   (box_min_q[a]),
      .box_max_i   (box_max_q[a]),
      .near_t_o    (near_t[a]),
      .far_t_o     (far_t[a]),
      .near_face_o (near_face[a]),
      .far_face_o  (far_face[a])
    );
  end

  // ---------------------------------------------------------------------------
  // Reduction over the axes in x, y, z order. Entry starts at the ray's lower
  // bound and only rises on a strictly larger near distance; exit starts at the
  // largest value and only falls on a strictly smaller far distance.
  // ---------------------------------------------------------------------------
  logic signed [CB-1:0] tin_d, tout_d;
  face_t                fin_d, fout_d;

  always_comb begin
    tin_d  = tmin_q[ST_ORDER];
    tout_d = T_MAX;
    fin_d  = FACE_NONE;
    fout_d = FACE_NONE;
    for (int i = 0; i < NUM_AXES; i++) begin
      if (near_t[i] > tin_d) begin
        tin_d = near_t[i];
        fin_d = near_face[i];
      end
      if (far_t[i] < tout_d) begin
        tout_d = far_t[i];
        fout_d = far_face[i];
      end
    end
  end

  logic signed [CB-1:0] tin_q, tout_q, closest_red_q;
  face_t                fin_q, fout_q;

  always_ff @(posedge clk_i) begin
    if (rdy[ST_REDUCE]) begin
      tin_q         <= tin_d;
      tout_q        <= tout_d;
      fin_q         <= fin_d;
      fout_q        <= fout_d;
      closest_red_q <= closest_q[ST_ORDER];
    end
  end

  // ---------------------------------------------------------------------------
  // Hit decision and output register. A miss reports all fields as zero.
  // ---------------------------------------------------------------------------
  logic                 hit_d;
  logic                 out_hit_q;
  logic signed [CB-1:0] out_entry_t_q, out_exit_t_q;
  face_t                out_entry_face_q, out_exit_face_q;

  assign hit_d = (tin_q < tout_q) && (tin_q > 0) && (tin_q < closest_red_q);

  always_ff @(posedge clk_i) begin
    if (rdy[ST_OUT]) begin
      out_hit_q        <= hit_d;
      out_entry_t_q    <= hit_d ? tin_q  : '0;
      out_exit_t_q     <= hit_d ? tout_q : '0;
      out_entry_face_q <= hit_d ? fin_q  : FACE_NONE;
      out_exit_face_q  <= hit_d ? fout_q : FACE_NONE;
    end
  end

  assign m_axis_tdata = OUT_TDATA_W'({out_exit_face_q, out_entry_face_q,
                                      out_exit_t_q, out_entry_t_q, out_hit_q});

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // A miss never leaks distances or faces.
  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !out_hit_q |->
      out_entry_t_q == '0 && out_exit_t_q == '0 &&
      out_entry_face_q == FACE_NONE && out_exit_face_q == FACE_NONE)
    else $error("miss result carries nonzero fields");

  // A hit always has a positive entry before its exit.
  a_hit_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_hit_q |-> out_entry_t_q > 0 && out_entry_t_q < out_exit_t_q)
    else $error("hit result with misordered distances");

  // An exit that was never lowered stays at the largest distance.
  a_exit_untouched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_hit_q && out_exit_face_q == FACE_NONE |-> out_exit_t_q == T_MAX)
    else $error("exit face none but exit distance lowered");

  // The input side only backs off when every stage holds a ray.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> &vld_q)
    else $error("input stalled while the pipeline has a free stage");

  // A result held by the sink is still there in the next cycle.
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_OUT] && !m_axis_tready |=> vld_q[ST_OUT] && $stable(out_entry_t_q))
    else $error("output stage dropped a stalled result");

endmodule
